// ===== hdl/handle_table_allocator_unit_assert.svh =====
// Assertion macros of the handle table allocator, used by hta_ctrl.
`ifndef HANDLE_TABLE_ALLOCATOR_UNIT_ASSERT_SVH
`define HANDLE_TABLE_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HTA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hta assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define HTA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hta assertion failed");

`endif

// ===== hdl/hta_pkg.sv =====
// Types, codes and constants of the handle table allocator.
package hta_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int CMD_W           = 2;
  localparam int OBJ_W           = 32;
  localparam int HND_W           = 8;
  localparam int STATUS_W        = 2;
  localparam int HOUT_W          = 6;
  localparam int LIMIT_W         = 7;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_ADDR_W      = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(64);

  localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_ENTRY = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [OBJ_W-1:0] object_value;
    logic [HND_W-1:0] handle_index;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HOUT_W-1:0]   handle_out;
    logic [OBJ_W-1:0]    object_out;
  } out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic exec;
    logic respond;
  } ctl_t;

endpackage

// ===== hdl/hta_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module hta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/hta_ctrl.sv =====
// Transaction sequencer of the handle table allocator.
`include "handle_table_allocator_unit_assert.svh"

module hta_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output hta_pkg::ctl_t ctl
);
  import hta_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   take;

  assign busy = (state_r == ST_EXEC);
  assign take = start && !busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: state_nxt = take ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_nxt = ST_RESP;
      // a new transaction may start while the result is on the ports
      ST_RESP: state_nxt = take ? ST_EXEC : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign ctl.capture = take;
  assign ctl.exec    = (state_r == ST_EXEC);
  assign ctl.respond = (state_r == ST_RESP);

  `HTA_ASSERT_NEXT(a_take_then_exec, take, ctl.exec)
  `HTA_ASSERT_NEXT(a_exec_then_resp, ctl.exec, ctl.respond && !busy)
  `HTA_ASSERT_NOW(a_resp_after_exec, ctl.respond, $past(ctl.exec))
  `HTA_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state_r))

endmodule

// ===== hdl/hta_dp.sv =====
// Datapath: valid bits, free-slot search, object store and result registers.
module hta_dp #(
  parameter int TABLE_DEPTH = hta_pkg::TABLE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hta_pkg::ctl_t               ctl,
  input  hta_pkg::in_t                in_data,
  input  logic [hta_pkg::LIMIT_W-1:0] table_limit,
  output hta_pkg::out_t               out_data
);
  import hta_pkg::*;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int LIM_W = $clog2(TABLE_DEPTH + 1);
  localparam int CW    = (LIM_W > HND_W) ? LIM_W : HND_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  in_t                  req_r;
  logic [TABLE_DEPTH-1:0] valid_r, valid_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [HOUT_W-1:0]    hout_r, hout_nxt;
  logic                 hit_r, hit_nxt;

  logic [CW-1:0]        lim_ext, lim, hnd_ext;
  logic                 in_rng;
  logic [AW-1:0]        haddr;
  logic [TABLE_DEPTH-1:0] free;
  logic                 found;
  logic [AW-1:0]        slot;
  logic                 ram_we, ram_re;
  logic [OBJ_W-1:0]     ram_rdata;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      req_r <= in_data;
    end
  end

  // active limit saturates at the table depth
  assign lim_ext = CW'(table_limit);
  assign lim     = (lim_ext > DEPTH_C) ? DEPTH_C : lim_ext;
  assign hnd_ext = CW'(req_r.handle_index);
  assign in_rng  = hnd_ext < lim;
  assign haddr   = hnd_ext[AW-1:0];

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      free[i] = !valid_r[i] && (CW'(i) < lim);
    end
  end

  // lowest free slot: scan downwards so the lowest hit is kept
  always_comb begin
    found = 1'b0;
    slot  = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (free[i]) begin
        found = 1'b1;
        slot  = AW'(i);
      end
    end
  end

  always_comb begin
    valid_nxt  = valid_r;
    status_nxt = status_r;
    hout_nxt   = hout_r;
    hit_nxt    = hit_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    if (ctl.exec) begin
      status_nxt = STATUS_OK;
      hout_nxt   = '0;
      hit_nxt    = 1'b0;
      case (req_r.cmd)
        CMD_CREATE: begin
          if (req_r.object_value == '0) begin
            status_nxt = STATUS_INVALID;
          end else if (found) begin
            ram_we          = 1'b1;
            valid_nxt[slot] = 1'b1;
            hout_nxt        = HOUT_W'(slot);
          end else begin
            status_nxt = STATUS_FULL;
          end
        end
        CMD_LOOKUP: begin
          if (!in_rng) begin
            status_nxt = STATUS_INVALID;
          end else if (!valid_r[haddr]) begin
            status_nxt = STATUS_NO_ENTRY;
          end else begin
            ram_re  = 1'b1;
            hit_nxt = 1'b1;
          end
        end
        CMD_DELETE: begin
          if (in_rng) begin
            valid_nxt[haddr] = 1'b0;
          end
        end
        default: status_nxt = STATUS_INVALID;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    hout_r   <= hout_nxt;
    hit_r    <= hit_nxt;
  end

  hta_ram #(
    .WIDTH (OBJ_W),
    .DEPTH (TABLE_DEPTH)
  ) u_obj_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (req_r.object_value),
    .re    (ram_re),
    .raddr (haddr),
    .rdata (ram_rdata)
  );

  assign out_data.status     = status_r;
  assign out_data.handle_out = hout_r;
  assign out_data.object_out = hit_r ? ram_rdata : '0;

endmodule

// ===== hdl/handle_table_allocator_unit.sv =====
// Top level of the handle table allocator: configuration register and wiring.
//
// Handle table with TABLE_DEPTH slots. A transaction is taken when start is high and busy is
// low; its result appears on out_data with out_valid high for exactly one cycle, in the result
// state that follows the execute state, and the receiver cannot stall it. Each transaction
// passes through an execute state, in which the valid-bit priority encoder picks the lowest
// free slot and the object memory does its single read or write, then the result state,
// during which the next start is already taken. Slot occupancy is held in valid bits cleared
// at reset, so the block is ready straight out of reset with no clearing pass. table_limit
// (APB address 0, reset 64) may be changed only while the block is idle.
module handle_table_allocator_unit #(
  parameter int TABLE_DEPTH = hta_pkg::TABLE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  hta_pkg::in_t                   in_data,
  output logic                           out_valid,
  output hta_pkg::out_t                  out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hta_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [hta_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [hta_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import hta_pkg::*;

  ctl_t               ctl;
  logic [LIMIT_W-1:0] limit_r;
  logic               cfg_wr;

  // single word register; the byte offset within it is ignored
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == paddr);
  assign prdata = CFG_DATA_W'(limit_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr) begin
      limit_r <= pwdata[LIMIT_W-1:0];
    end
  end

  hta_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  hta_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .in_data     (in_data),
    .table_limit (limit_r),
    .out_data    (out_data)
  );

  assign out_valid = ctl.respond;

endmodule
